>>> rtl/core/i2cmbs_pkg.sv
`default_nettype none
package i2cmbs_pkg;

    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_STOP    = 3'd1;
    localparam logic [2:0] REQ_TX_BYTE = 3'd2;
    localparam logic [2:0] REQ_RX_BYTE = 3'd3;
    localparam logic [2:0] REQ_TX_ACK  = 3'd4;
    localparam logic [2:0] REQ_RX_ACK  = 3'd5;

    localparam int unsigned BYTE_W = 8;

    typedef struct packed {
        logic load;     // capture a new byte
        logic load_rx;  // byte comes from the bus sample levels
        logic shift;    // advance one bit, MSB first
    } t_shift_ctl;

endpackage
`default_nettype wire

>>> rtl/core/i2cmbs_shift.sv
`default_nettype none
module i2cmbs_shift (
    input  wire logic                               i_clk,
    input  wire i2cmbs_pkg::t_shift_ctl             i_ctl,
    input  wire logic [i2cmbs_pkg::BYTE_W-1:0]      i_tx_byte,
    input  wire logic [i2cmbs_pkg::BYTE_W-1:0]      i_bus_sda_bits,
    output logic                                    o_msb,
    output logic [i2cmbs_pkg::BYTE_W-1:0]           o_rx_next
);

    logic [i2cmbs_pkg::BYTE_W-1:0] r_data;
    logic [i2cmbs_pkg::BYTE_W-1:0] r_rx;

    assign o_msb     = r_data[i2cmbs_pkg::BYTE_W-1];
    // receive path: the current bus bit enters the rx shifter from the right
    assign o_rx_next = {r_rx[i2cmbs_pkg::BYTE_W-2:0], r_data[i2cmbs_pkg::BYTE_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_ctl.load_rx ? i_bus_sda_bits : i_tx_byte;
        end else if (i_ctl.shift) begin
            r_data <= {r_data[i2cmbs_pkg::BYTE_W-2:0], 1'b0};
            r_rx   <= o_rx_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/i2cmbs_seq.sv
`default_nettype none
module i2cmbs_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [2:0]                     i_req_type,
    input  wire logic                           i_ack_out,
    input  wire logic                           i_bus_ack_level,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_scl_level,
    output logic                                o_sda_level,
    output logic                                o_sample_point,
    output logic [i2cmbs_pkg::BYTE_W-1:0]       o_rx_byte,
    output logic                                o_ack_in,
    output logic                                o_last,
    output i2cmbs_pkg::t_shift_ctl              o_shift_ctl,
    input  wire logic                           i_msb,
    input  wire logic [i2cmbs_pkg::BYTE_W-1:0]  i_rx_next
);

    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;
    localparam logic [1:0] PH_3 = 2'd3;
    localparam logic [2:0] LAST_BIT = 3'(i2cmbs_pkg::BYTE_W - 1);

    logic       r_busy;
    logic [2:0] r_req;
    logic [1:0] r_phase;
    logic [2:0] r_bit;
    logic       r_scl;
    logic       r_sda;
    logic       r_ack;
    logic       r_out_valid;
    logic       r_o_scl;
    logic       r_o_sda;
    logic       r_o_sample;
    logic [i2cmbs_pkg::BYTE_W-1:0] r_o_rx;
    logic       r_o_ack;
    logic       r_o_last;

    logic       n_scl;
    logic       n_sda;
    logic       n_sample;
    logic [i2cmbs_pkg::BYTE_W-1:0] n_rx;
    logic       n_ack;
    logic       n_last;
    logic       n_shift;
    logic       accept;
    logic       emit;
    logic       req_ok;
    logic       byte_cmd;

    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign emit       = r_busy && (!r_out_valid || i_out_ready);
    // codes above receive ack are dropped without events
    assign req_ok     = (i_req_type <= i2cmbs_pkg::REQ_RX_ACK);
    assign byte_cmd   = (r_req == i2cmbs_pkg::REQ_TX_BYTE) ||
                        (r_req == i2cmbs_pkg::REQ_RX_BYTE);

    assign o_shift_ctl.load    = accept;
    assign o_shift_ctl.load_rx = (i_req_type == i2cmbs_pkg::REQ_RX_BYTE);
    assign o_shift_ctl.shift   = emit && n_shift;

    always_comb begin
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_sample = 1'b0;
        n_rx     = '0;
        n_ack    = 1'b0;
        n_last   = 1'b0;
        n_shift  = 1'b0;
        case (r_req)
            i2cmbs_pkg::REQ_START: begin
                case (r_phase)
                    PH_0:    n_sda = 1'b1;
                    PH_1:    n_scl = 1'b1;
                    PH_2:    n_sda = 1'b0;
                    default: begin
                        n_scl  = 1'b0;
                        n_last = 1'b1;
                    end
                endcase
            end
            i2cmbs_pkg::REQ_STOP: begin
                case (r_phase)
                    PH_0:    n_sda = 1'b0;
                    PH_1:    n_scl = 1'b1;
                    default: begin
                        n_sda  = 1'b1;
                        n_last = 1'b1;
                    end
                endcase
            end
            i2cmbs_pkg::REQ_TX_BYTE,
            i2cmbs_pkg::REQ_RX_BYTE: begin
                case (r_phase)
                    PH_0:    n_sda = (r_req == i2cmbs_pkg::REQ_TX_BYTE) ? i_msb : 1'b1;
                    PH_1: begin
                        n_scl    = 1'b1;
                        n_sample = (r_req == i2cmbs_pkg::REQ_RX_BYTE);
                    end
                    default: begin
                        n_scl   = 1'b0;
                        n_shift = 1'b1;
                        n_last  = (r_bit == LAST_BIT);
                        if ((r_req == i2cmbs_pkg::REQ_RX_BYTE) && (r_bit == LAST_BIT)) begin
                            n_rx = i_rx_next;
                        end
                    end
                endcase
            end
            i2cmbs_pkg::REQ_TX_ACK,
            i2cmbs_pkg::REQ_RX_ACK: begin
                case (r_phase)
                    PH_0:    n_sda = (r_req == i2cmbs_pkg::REQ_TX_ACK) ? r_ack : 1'b1;
                    PH_1: begin
                        n_scl    = 1'b1;
                        n_sample = (r_req == i2cmbs_pkg::REQ_RX_ACK);
                    end
                    default: begin
                        n_scl  = 1'b0;
                        n_last = 1'b1;
                        n_ack  = (r_req == i2cmbs_pkg::REQ_RX_ACK) ? r_ack : 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_req       <= i2cmbs_pkg::REQ_START;
            r_phase     <= PH_0;
            r_bit       <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && req_ok) begin
                r_busy  <= 1'b1;
                r_req   <= i_req_type;
                r_phase <= PH_0;
                r_bit   <= '0;
            end
            if (emit) begin
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
                if (n_last) begin
                    r_busy <= 1'b0;
                end else if (byte_cmd && (r_phase == PH_2)) begin
                    r_phase <= PH_0;
                    r_bit   <= r_bit + 3'd1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ack <= (i_req_type == i2cmbs_pkg::REQ_TX_ACK) ? i_ack_out : i_bus_ack_level;
        end
        if (emit) begin
            r_o_scl    <= n_scl;
            r_o_sda    <= n_sda;
            r_o_sample <= n_sample;
            r_o_rx     <= n_rx;
            r_o_ack    <= n_ack;
            r_o_last   <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_o_scl;
    assign o_sda_level    = r_o_sda;
    assign o_sample_point = r_o_sample;
    assign o_rx_byte      = r_o_rx;
    assign o_ack_in       = r_o_ack;
    assign o_last         = r_o_last;

    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_last) |=> !r_busy)
        else $error("command did not end on its last event");

    a_sample_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_sample) |-> r_o_scl)
        else $error("sample point with SCL low");

    a_rx_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_last) |-> ((r_o_rx == '0) && !r_o_ack))
        else $error("receive data outside the last event");

    a_bit_idle_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !byte_cmd) |-> (r_bit == '0))
        else $error("bit counter moved in a non-byte command");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_req != i2cmbs_pkg::REQ_START)) |-> (r_phase != PH_3))
        else $error("phase out of range");

endmodule
`default_nettype wire

>>> rtl/core/i2c_master_bit_sequencer.sv
// Open-drain I2C master bit engine. One command word (start, stop, send byte, receive
// byte, send ack, receive ack) is taken while the engine is idle and turns into a run of
// pin events on the output channel, one event per cycle while the output is taken: start
// 4, stop 3, byte 24, ack 3. The engine takes no new command until its last event is
// out; the byte count is set by the phase counter stepping three events per bit through
// an 8-bit shifter. Each event reports both pin levels after the change; sample_point
// marks the SCL-high event where SDA is read. The bus levels for receives come in with the
// command; the received byte or ack shows on the last event. SCL and SDA reset released.
// Unused command codes are accepted and dropped. Event spacing on the real pins is up to
// the pin timing logic downstream.
`default_nettype none
module i2c_master_bit_sequencer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_req_type,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_ack_out,
    input  wire logic [7:0] i_bus_sda_bits,
    input  wire logic       i_bus_ack_level,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_scl_level,
    output logic            o_sda_level,
    output logic            o_sample_point,
    output logic [7:0]      o_rx_byte,
    output logic            o_ack_in,
    output logic            o_last
);

    i2cmbs_pkg::t_shift_ctl              shift_ctl;
    logic                                msb;
    logic [i2cmbs_pkg::BYTE_W-1:0]       rx_next;

    i2cmbs_shift u_shift (
        .i_clk          (i_clk),
        .i_ctl          (shift_ctl),
        .i_tx_byte      (i_tx_byte),
        .i_bus_sda_bits (i_bus_sda_bits),
        .o_msb          (msb),
        .o_rx_next      (rx_next)
    );

    i2cmbs_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_ack_out       (i_ack_out),
        .i_bus_ack_level (i_bus_ack_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_scl_level     (o_scl_level),
        .o_sda_level     (o_sda_level),
        .o_sample_point  (o_sample_point),
        .o_rx_byte       (o_rx_byte),
        .o_ack_in        (o_ack_in),
        .o_last          (o_last),
        .o_shift_ctl     (shift_ctl),
        .i_msb           (msb),
        .i_rx_next       (rx_next)
    );

endmodule
`default_nettype wire
